>>> hdl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// shared widths, defaults and unit status type for the modular exponentiator
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int unsigned FIELD_W    = 62;
  localparam int unsigned WIDTH_DEF  = 62;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } mme_stat_t;

endpackage

`default_nettype wire

>>> hdl/mme_mulmod.sv
// ----------------------------------------------------------------------------
// mme_mulmod
// bit-serial modular multiplier, a * b mod m, one bit of b per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mulmod #(
  parameter int unsigned WIDTH = mme_pkg::WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire  [WIDTH-1:0]      a_in,
  input  wire  [WIDTH-1:0]      b_in,
  input  wire  [WIDTH-1:0]      m_in,
  output logic [WIDTH-1:0]      result,
  output mme_pkg::mme_stat_t    stat
);

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [WIDTH:0] m_ext;
  logic [WIDTH:0] acc_sum;
  logic [WIDTH:0] acc_red;
  logic [WIDTH:0] a_dbl;
  logic [WIDTH:0] a_red;

  assign m_ext   = {1'b0, m_in};
  // accumulate path and doubling path run side by side
  assign acc_sum = {1'b0, acc_r} + {1'b0, a_r};
  assign acc_red = (acc_sum >= m_ext) ? (acc_sum - m_ext) : acc_sum;
  assign a_dbl   = {a_r, 1'b0};
  assign a_red   = (a_dbl >= m_ext) ? (a_dbl - m_ext) : a_dbl;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a_in;
      b_nxt    = b_in;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_red[WIDTH-1:0];
      end
      a_nxt   = a_red[WIDTH-1:0];
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign result    = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("mulmod done without a running product");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("mulmod started while busy");
`endif

endmodule

`default_nettype wire

>>> hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// value^exponent mod modulus by right-to-left square-and-multiply on a shared
// bit-serial modular multiplier, with an apb register port for the key
// ----------------------------------------------------------------------------
// sequence: reduce the word by a product, then per exponent bit up to its top
//   set bit, a step state, a multiply into the accumulator when the bit is set
//   and a square of the base, then a finish state that loads the output register
// a modulus of 0 or 1 goes straight to finish with a result of 0; one word at
//   a time, the next word is taken once the result is registered
// reset: synchronous active-low, exponent and modulus return to 1
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned WIDTH = mme_pkg::WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [mme_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire  [mme_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mme_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [mme_pkg::FIELD_W-1:0]         in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mme_pkg::FIELD_W-1:0]         out_power_result,
  output logic                                out_value_too_large,
  output logic                                out_modulus_zero
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_STEP   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

  logic [2:0]       state_r, state_nxt;
  logic [WIDTH-1:0] exponent_r;
  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic             too_large_r, too_large_nxt;
  logic             mzero_r, mzero_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic             res_large_r, res_large_nxt;
  logic             res_mzero_r, res_mzero_nxt;

  logic             cfg_wr;
  logic             in_acc;
  logic [WIDTH-1:0] v_word;

  logic             mul_start;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic [WIDTH-1:0] mul_res;
  mme_pkg::mme_stat_t mul_stat;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[3]) begin
      prdata[WIDTH-1:0] = modulus_r;
    end else begin
      prdata[WIDTH-1:0] = exponent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= ONE;
      modulus_r  <= ONE;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        modulus_r <= pwdata[WIDTH-1:0];
      end else begin
        exponent_r <= pwdata[WIDTH-1:0];
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign v_word   = in_value[WIDTH-1:0];

  mme_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a_in   (mul_a),
    .b_in   (mul_b),
    .m_in   (modulus_r),
    .result (mul_res),
    .stat   (mul_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    too_large_nxt = too_large_r;
    mzero_nxt     = mzero_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    res_large_nxt = res_large_r;
    res_mzero_nxt = res_mzero_r;
    mul_start     = 1'b0;
    mul_a         = base_r;
    mul_b         = base_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          too_large_nxt = (v_word >= modulus_r);
          mzero_nxt     = (modulus_r == '0);
          acc_nxt       = '0;
          if (modulus_r <= ONE) begin
            state_nxt = ST_FIN;
          end else begin
            // value mod m as 1 * value mod m
            mul_start = 1'b1;
            mul_a     = ONE;
            mul_b     = v_word;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) begin
          base_nxt  = mul_res;
          acc_nxt   = ONE;
          e_nxt     = exponent_r;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (e_r == '0) begin
          state_nxt = ST_FIN;
        end else if (e_r[0]) begin
          mul_start = 1'b1;
          mul_a     = acc_r;
          mul_b     = base_r;
          state_nxt = ST_MUL;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          acc_nxt   = mul_res;
          mul_start = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_stat.done) begin
          base_nxt  = mul_res;
          e_nxt     = e_r >> 1;
          state_nxt = ST_STEP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          res_nxt       = acc_r;
          res_large_nxt = too_large_r;
          res_mzero_nxt = mzero_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    acc_r       <= acc_nxt;
    e_r         <= e_nxt;
    too_large_r <= too_large_nxt;
    mzero_r     <= mzero_nxt;
    res_r       <= res_nxt;
    res_large_r <= res_large_nxt;
    res_mzero_r <= res_mzero_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_power_result    = mme_pkg::FIELD_W'(res_r);
  assign out_value_too_large = res_large_r;
  assign out_modulus_zero    = res_mzero_r;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_stat.busy || mul_stat.done) |->
      (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR))
    else $error("product running outside a run");

  a_prod_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (mul_res < modulus_r))
    else $error("product not reduced below modulus");

  a_mzero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_mzero_r) |-> (res_r == '0 && res_large_r))
    else $error("zero modulus word has nonzero result or clear flag");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted word did not start a run");
`endif

endmodule

`default_nettype wire

>>> tb/sv/modular_exponentiation_test.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// drives words through the modular exponentiator under several keys written
// over the apb port, predicts value^exponent mod modulus with both flags, and
// compares every returned word in order; both channels idle at random
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_test;

  localparam int unsigned FIELD_W    = mme_pkg::FIELD_W;
  localparam int unsigned APB_ADDR_W = mme_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W = mme_pkg::APB_DATA_W;

  localparam int unsigned REG_EXPONENT = 0;
  localparam int unsigned REG_MODULUS  = 1;
  localparam logic [FIELD_W-1:0] FMASK = {FIELD_W{1'b1}};
  localparam int unsigned IDLE_LIMIT   = 100000;
  localparam int unsigned HOLD_CYCLES  = 20000;
  localparam int unsigned RANDOM_WORDS = 80;

  typedef struct packed {
    logic [FIELD_W-1:0] power;
    logic               too_large;
    logic               mod_zero;
  } power_word_t;

  class expo_scoreboard;
    logic [FIELD_W-1:0] exponent_q;
    logic [FIELD_W-1:0] modulus_q;
    power_word_t        pending_q[$];
    int unsigned        mismatches;

    function new();
      exponent_q = 1;
      modulus_q  = 1;
      mismatches = 0;
    endfunction

    function void set_key(logic [FIELD_W-1:0] e, logic [FIELD_W-1:0] m);
      exponent_q = e;
      modulus_q  = m;
    endfunction

    function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] acc;
      int          i;
      acc = 0;
      for (i = 0; i < FIELD_W; i++) begin
        if (b[i]) begin
          acc = acc + a;
          if (acc >= m) acc = acc - m;
        end
        a = a << 1;
        if (a >= m) a = a - m;
      end
      return acc;
    endfunction

    function logic [FIELD_W-1:0] expmod(logic [63:0] v, logic [63:0] e, logic [63:0] m);
      logic [63:0] base;
      logic [63:0] acc;
      int          i;
      if (m <= 1) return '0;
      base = v % m;
      acc  = 1;
      for (i = 0; i < FIELD_W; i++) begin
        if (e[i]) acc = mulmod(acc, base, m);
        base = mulmod(base, base, m);
      end
      return acc[FIELD_W-1:0];
    endfunction

    function void note_word(logic [FIELD_W-1:0] v);
      power_word_t w;
      w.power     = expmod({2'b00, v}, {2'b00, exponent_q}, {2'b00, modulus_q});
      w.too_large = (v >= modulus_q);
      w.mod_zero  = (modulus_q == 0);
      pending_q   = {pending_q, w};
    endfunction

    function void check_word(logic [FIELD_W-1:0] p, logic tl, logic mz);
      power_word_t w;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: power %h too_large %b modulus_zero %b", p, tl, mz);
        return;
      end
      w = pending_q.pop_front();
      if (w.power !== p || w.too_large !== tl || w.mod_zero !== mz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: power exp %h got %h, too_large exp %b got %b, %s %b got %b",
                   w.power, p, w.too_large, tl, "modulus_zero exp", w.mod_zero, mz);
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FIELD_W-1:0]    in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FIELD_W-1:0]    out_power_result;
  logic                  out_value_too_large;
  logic                  out_modulus_zero;

  expo_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;
  logic           hold_req = 1'b0;

  modular_exponentiation i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_power_result    (out_power_result),
    .out_value_too_large (out_value_too_large),
    .out_modulus_zero    (out_modulus_zero)
  );

  always #1 clk = ~clk;

  function automatic logic [FIELD_W-1:0] rand_bits(int unsigned w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (w == 0) return '0;
    return r[FIELD_W-1:0] >> (FIELD_W - w);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_power_result, out_value_too_large, out_modulus_zero);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: rotating stall modes, plus one long hold-off on request
  initial begin
    int unsigned cyc;
    logic [7:0]  mask;
    cyc  = 0;
    mask = 8'b1011_0010;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        cyc++;
        case ((cyc / 64) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= mask[cyc % 8];
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input int unsigned idx, input logic [FIELD_W-1:0] val);
    logic [1:0] junk;
    junk = $urandom_range(0, 3);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 8);
    pwdata  <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_key(input logic [FIELD_W-1:0] e, input logic [FIELD_W-1:0] m);
    write_reg(REG_EXPONENT, e);
    write_reg(REG_MODULUS, m);
    sb.set_key(e, m);
  endtask

  task automatic send_word(input logic [FIELD_W-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_word(v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // sender stops until every pending word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [FIELD_W-1:0] e;
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] v;
    int unsigned        n;
    int unsigned        sent;
    int unsigned        phase;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: exponent 1, modulus 1
    send_word('0);
    send_word(FMASK);
    drain();

    // modulus zero
    program_key(5, 0);
    send_word('0);
    send_word(123);
    drain();

    // exponent zero
    program_key(0, 1000003);
    send_word('0);
    send_word(999);
    send_word(1000003);
    send_word(FMASK);
    drain();

    // full-width key
    program_key(FMASK, FMASK);
    send_word('0);
    send_word(1);
    send_word(2);
    send_word(FMASK - 1);
    send_word(FMASK);
    drain();

    program_key(65537, 3233);
    send_word(65);
    send_word(3232);
    send_word(3233);
    send_word(5000);
    drain();

    program_key(1, 2);
    send_word('0);
    send_word(1);
    send_word(3);
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        e = rand_bits(FIELD_W) | (62'd1 << (FIELD_W - 1));
        n = 2;
      end else begin
        e = rand_bits($urandom_range(0, 20));
        n = $urandom_range(4, 12);
      end
      case ($urandom_range(0, 15))
        0:       m = 0;
        1:       m = 1;
        default: m = rand_bits($urandom_range(2, FIELD_W));
      endcase
      program_key(e, m);
      if (phase == 2) hold_req = 1'b1;
      repeat (n) begin
        v = rand_bits(FIELD_W);
        if (m > 1 && $urandom_range(0, 3) != 0) v = v % m;
        send_word(v);
      end
      drain();
      sent += n;
      phase++;
    end

    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
